FILE: design/cffa_pkg.sv
package cffa_pkg;

   // Default sizes of the device bitmap and the file table.
   localparam int CFFA_BLOCKS    = 256;
   localparam int CFFA_MAX_FILES = 16;

   // The scan never goes beyond this many blocks, whatever the bitmap size.
   localparam int MAP_LIMIT = 256;

   // Field widths.
   localparam int KEY_W   = 32;
   localparam int START_W = 8;
   localparam int LEN_W   = 9;
   localparam int IDX_W   = 8;

   // Request commands.
   localparam logic CMD_CREATE = 1'b0;
   localparam logic CMD_DELETE = 1'b1;

   // Result status codes.
   typedef enum logic [2:0] {
      STATUS_OK        = 3'd0,
      STATUS_EXISTS    = 3'd1,
      STATUS_NO_RUN    = 3'd2,
      STATUS_NOT_FOUND = 3'd3,
      STATUS_FULL      = 3'd4
   } status_type;

   // One request transfer.
   typedef struct packed {
      logic               cmd;
      logic [KEY_W-1:0]   file_key;
      logic [LEN_W-1:0]   block_count;
   } req_type;

   // One result transfer.
   typedef struct packed {
      status_type         status;
      logic [START_W-1:0] start_block;
      logic [LEN_W-1:0]   length;
   } rsp_type;

   // One file table entry.
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [START_W-1:0] start;
      logic [LEN_W-1:0]   length;
   } entry_type;

   // Write and clear commands to the file table.
   typedef struct packed {
      logic               wr_en;
      logic               clr_en;
      logic [IDX_W-1:0]   idx;
      entry_type          entry;
   } tbl_cmd_type;

   // Single-bit write command to the block bitmap.
   typedef struct packed {
      logic               wr_en;
      logic               wr_bit;
      logic [IDX_W-1:0]   wr_idx;
   } map_cmd_type;

endpackage

FILE: design/contiguous_first_fit_allocator_core.sv
// A request passes through a lookup of the file table, each entry read and then compared,
// stopping early on a key hit; a decision; on create a scan of at most T blocks with
// T = min(total_blocks, BLOCKS, 256); marking or freeing the run block by block; the result.
// The input stalls throughout; the next request is taken in the cycle after the result is
// loaded, later while an earlier result is still stalled. Reset empties the table, sets
// total_blocks to 256 and stalls the input during a clearing pass over the bitmap.
module contiguous_first_fit_allocator_core import cffa_pkg::*; #(
   parameter int BLOCKS    = CFFA_BLOCKS,
   parameter int MAX_FILES = CFFA_MAX_FILES
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output rsp_type          rsp_data,
   input  logic             csr_wr_en,
   input  logic [LEN_W-1:0] csr_wr_data
);

   localparam int MAP_DEPTH = (BLOCKS < MAP_LIMIT) ? BLOCKS : MAP_LIMIT;
   localparam int MAP_AW    = $clog2(MAP_DEPTH);
   localparam int ENT_AW    = $clog2(MAX_FILES);
   localparam logic [LEN_W-1:0] MAP_DEPTH_L = LEN_W'(MAP_DEPTH);
   localparam logic [LEN_W-1:0] MAX_FILES_L = LEN_W'(MAX_FILES);

   typedef enum logic [5:0] {
      S_IDLE   = 6'b000001,
      S_LOOKUP = 6'b000010,
      S_DECIDE = 6'b000100,
      S_SCAN   = 6'b001000,
      S_FILL   = 6'b010000,
      S_DONE   = 6'b100000
   } state_type;

   state_type            state_ff, state_in;
   logic                 cmd_ff, cmd_in;
   logic [KEY_W-1:0]     key_ff, key_in;
   logic [LEN_W-1:0]     need_ff, need_in;
   logic [ENT_AW-1:0]    ent_idx_ff, ent_idx_in;
   logic                 phase_ff, phase_in;
   logic                 hit_ff, hit_in;
   logic [ENT_AW-1:0]    hit_idx_ff, hit_idx_in;
   logic [START_W-1:0]   hit_start_ff, hit_start_in;
   logic [LEN_W-1:0]     hit_len_ff, hit_len_in;
   logic                 free_found_ff, free_found_in;
   logic [ENT_AW-1:0]    free_idx_ff, free_idx_in;
   logic [LEN_W-1:0]     blk_idx_ff, blk_idx_in;
   logic [LEN_W-1:0]     run_ff, run_in;
   logic [START_W-1:0]   run_start_ff, run_start_in;
   logic [LEN_W-1:0]     cnt_ff, cnt_in;
   logic                 fill_val_ff, fill_val_in;
   rsp_type              res_ff, res_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [LEN_W-1:0]     total_blocks_ff, total_blocks_in;

   logic [LEN_W-1:0]     dev_size;
   logic [LEN_W-1:0]     step_a, step_b, step_sum;
   logic                 step_reach;
   logic                 map_rd_bit;
   logic                 map_busy;
   map_cmd_type          map_cmd;
   tbl_cmd_type          tbl_cmd;
   entry_type            tbl_rd_entry;
   logic                 tbl_rd_valid;
   logic [START_W-1:0]   start_now;

   // Shared increment and compare unit.
   cffa_step_unit u_step (
      .op_a  (step_a),
      .op_b  (step_b),
      .sum   (step_sum),
      .reach (step_reach)
   );

   // The bitmap is read ahead: its address is the next block index.
   cffa_block_map #(
      .MAP_DEPTH (MAP_DEPTH),
      .MAP_AW    (MAP_AW)
   ) u_map (
      .clock   (clock),
      .reset   (reset),
      .rd_idx  (blk_idx_in[MAP_AW-1:0]),
      .rd_bit  (map_rd_bit),
      .busy    (map_busy),
      .map_cmd (map_cmd)
   );

   cffa_file_table #(
      .MAX_FILES (MAX_FILES),
      .ENT_AW    (ENT_AW)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .rd_idx   (ent_idx_ff),
      .rd_entry (tbl_rd_entry),
      .rd_valid (tbl_rd_valid),
      .tbl_cmd  (tbl_cmd)
   );

   // Blocks scanned on create: the configured size, capped by the bitmap.
   assign dev_size = (total_blocks_ff > MAP_DEPTH_L) ? MAP_DEPTH_L : total_blocks_ff;

   // Start of the current free run if this block extends it.
   assign start_now = (run_ff == '0) ? blk_idx_ff[START_W-1:0] : run_start_ff;

   // Operand selection for the shared unit.
   always_comb begin
      step_a = '0;
      step_b = '0;
      if (state_ff == S_LOOKUP) begin
         step_a = LEN_W'(ent_idx_ff);
         step_b = MAX_FILES_L;
      end else if (state_ff == S_SCAN) begin
         step_a = run_ff;
         step_b = need_ff;
      end else if (state_ff == S_FILL) begin
         step_a = cnt_ff;
         step_b = res_ff.length;
      end
   end

   // Request sequencer.
   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      key_in          = key_ff;
      need_in         = need_ff;
      ent_idx_in      = ent_idx_ff;
      phase_in        = phase_ff;
      hit_in          = hit_ff;
      hit_idx_in      = hit_idx_ff;
      hit_start_in    = hit_start_ff;
      hit_len_in      = hit_len_ff;
      free_found_in   = free_found_ff;
      free_idx_in     = free_idx_ff;
      blk_idx_in      = blk_idx_ff;
      run_in          = run_ff;
      run_start_in    = run_start_ff;
      cnt_in          = cnt_ff;
      fill_val_in     = fill_val_ff;
      res_in          = res_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      total_blocks_in = csr_wr_en ? csr_wr_data : total_blocks_ff;
      map_cmd         = '0;
      tbl_cmd         = '0;

      // The waiting result leaves on a completed transfer.
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_valid && !map_busy) begin
               cmd_in        = req_data.cmd;
               key_in        = req_data.file_key;
               need_in       = req_data.block_count;
               ent_idx_in    = '0;
               phase_in      = 1'b0;
               hit_in        = 1'b0;
               free_found_in = 1'b0;
               state_in      = S_LOOKUP;
            end
         end

         // Each entry is read, then compared.
         S_LOOKUP: begin
            if (!phase_ff) begin
               phase_in = 1'b1;
            end else begin
               phase_in = 1'b0;
               if (tbl_rd_valid && tbl_rd_entry.key == key_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = ent_idx_ff;
                  hit_start_in = tbl_rd_entry.start;
                  hit_len_in   = tbl_rd_entry.length;
                  state_in     = S_DECIDE;
               end else begin
                  if (!tbl_rd_valid && !free_found_ff) begin
                     free_found_in = 1'b1;
                     free_idx_in   = ent_idx_ff;
                  end
                  if (step_reach) begin
                     state_in = S_DECIDE;
                  end else begin
                     ent_idx_in = step_sum[ENT_AW-1:0];
                  end
               end
            end
         end

         S_DECIDE: begin
            res_in   = '{status: STATUS_OK, start_block: '0, length: '0};
            state_in = S_DONE;
            if (cmd_ff == CMD_CREATE) begin
               if (hit_ff) begin
                  res_in.status = STATUS_EXISTS;
               end else if (!free_found_ff) begin
                  res_in.status = STATUS_FULL;
               end else if (need_ff == '0) begin
                  res_in.status = STATUS_NO_RUN;
               end else begin
                  blk_idx_in = '0;
                  run_in     = '0;
                  state_in   = S_SCAN;
               end
            end else begin
               if (!hit_ff) begin
                  res_in.status = STATUS_NOT_FOUND;
               end else begin
                  res_in.start_block = hit_start_ff;
                  res_in.length      = hit_len_ff;
                  tbl_cmd.clr_en     = 1'b1;
                  tbl_cmd.idx        = IDX_W'(hit_idx_ff);
                  blk_idx_in         = {1'b0, hit_start_ff};
                  cnt_in             = '0;
                  fill_val_in        = 1'b0;
                  state_in           = S_FILL;
               end
            end
         end

         // One block per cycle, lowest start first.
         S_SCAN: begin
            if (blk_idx_ff >= dev_size) begin
               res_in.status = STATUS_NO_RUN;
               state_in      = S_DONE;
            end else if (map_rd_bit) begin
               run_in     = '0;
               blk_idx_in = blk_idx_ff + LEN_W'(1);
            end else begin
               run_in       = step_sum;
               run_start_in = start_now;
               blk_idx_in   = blk_idx_ff + LEN_W'(1);
               if (step_reach) begin
                  res_in.start_block = start_now;
                  res_in.length      = need_ff;
                  tbl_cmd.wr_en      = 1'b1;
                  tbl_cmd.idx        = IDX_W'(free_idx_ff);
                  tbl_cmd.entry      = '{key: key_ff, start: start_now, length: need_ff};
                  blk_idx_in         = {1'b0, start_now};
                  cnt_in             = '0;
                  fill_val_in        = 1'b1;
                  state_in           = S_FILL;
               end
            end
         end

         // Mark or free the run, one block per cycle.
         S_FILL: begin
            map_cmd.wr_en  = 1'b1;
            map_cmd.wr_bit = fill_val_ff;
            map_cmd.wr_idx = IDX_W'(blk_idx_ff[MAP_AW-1:0]);
            blk_idx_in     = blk_idx_ff + LEN_W'(1);
            cnt_in         = step_sum;
            if (step_reach) begin
               state_in = S_DONE;
            end
         end

         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = S_IDLE;
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         rsp_valid_ff    <= 1'b0;
         total_blocks_ff <= MAP_LIMIT[LEN_W-1:0];
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         total_blocks_ff <= total_blocks_in;
      end
   end

   // Working and payload registers, set before each use.
   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      key_ff        <= key_in;
      need_ff       <= need_in;
      ent_idx_ff    <= ent_idx_in;
      phase_ff      <= phase_in;
      hit_ff        <= hit_in;
      hit_idx_ff    <= hit_idx_in;
      hit_start_ff  <= hit_start_in;
      hit_len_ff    <= hit_len_in;
      free_found_ff <= free_found_in;
      free_idx_ff   <= free_idx_in;
      blk_idx_ff    <= blk_idx_in;
      run_ff        <= run_in;
      run_start_ff  <= run_start_in;
      cnt_ff        <= cnt_in;
      fill_val_ff   <= fill_val_in;
      res_ff        <= res_in;
      rsp_data_ff   <= rsp_data_in;
   end

   assign req_stall = (state_ff != S_IDLE) || map_busy;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: design/cffa_step_unit.sv
module cffa_step_unit import cffa_pkg::*; (
   input  logic [LEN_W-1:0] op_a,
   input  logic [LEN_W-1:0] op_b,
   output logic [LEN_W-1:0] sum,
   output logic             reach
);

   // Shared incrementer and limit compare used by every loop of the sequencer.
   assign sum   = op_a + LEN_W'(1);
   assign reach = (sum >= op_b);

endmodule

FILE: design/cffa_block_map.sv
module cffa_block_map import cffa_pkg::*; #(
   parameter int MAP_DEPTH = MAP_LIMIT,
   parameter int MAP_AW    = $clog2(MAP_DEPTH)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [MAP_AW-1:0] rd_idx,
   output logic              rd_bit,
   output logic              busy,
   input  map_cmd_type       map_cmd
);

   localparam logic [MAP_AW-1:0] LAST_IDX = MAP_AW'(MAP_DEPTH - 1);

   logic              map_mem [MAP_DEPTH];
   logic              rd_bit_ff;
   logic              clr_busy_ff, clr_busy_in;
   logic [MAP_AW-1:0] clr_idx_ff, clr_idx_in;
   logic              wr_en;
   logic              wr_bit;
   logic [MAP_AW-1:0] wr_idx;

   // After reset the bitmap is cleared one block per cycle.
   always_comb begin
      clr_busy_in = clr_busy_ff;
      clr_idx_in  = clr_idx_ff;
      if (clr_busy_ff) begin
         clr_idx_in = clr_idx_ff + MAP_AW'(1);
         if (clr_idx_ff == LAST_IDX) begin
            clr_busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff <= 1'b1;
         clr_idx_ff  <= '0;
      end else begin
         clr_busy_ff <= clr_busy_in;
         clr_idx_ff  <= clr_idx_in;
      end
   end

   // The write port serves the clearing pass first, then the sequencer.
   assign wr_en  = clr_busy_ff || map_cmd.wr_en;
   assign wr_bit = clr_busy_ff ? 1'b0 : map_cmd.wr_bit;
   assign wr_idx = clr_busy_ff ? clr_idx_ff : map_cmd.wr_idx[MAP_AW-1:0];

   // In-use bitmap, one bit written and one bit read per cycle, registered read data.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_idx] <= wr_bit;
      end
      rd_bit_ff <= map_mem[rd_idx];
   end

   assign rd_bit = rd_bit_ff;
   assign busy   = clr_busy_ff;

endmodule

FILE: design/cffa_file_table.sv
module cffa_file_table import cffa_pkg::*; #(
   parameter int MAX_FILES = CFFA_MAX_FILES,
   parameter int ENT_AW    = $clog2(MAX_FILES)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic [ENT_AW-1:0] rd_idx,
   output entry_type         rd_entry,
   output logic              rd_valid,
   input  tbl_cmd_type       tbl_cmd
);

   entry_type            entry_mem [MAX_FILES];
   entry_type            rd_entry_ff;
   logic [MAX_FILES-1:0] valid_ff;

   // Entry storage with a registered read port.
   always_ff @(posedge clock) begin
      if (tbl_cmd.wr_en) begin
         entry_mem[tbl_cmd.idx[ENT_AW-1:0]] <= tbl_cmd.entry;
      end
      rd_entry_ff <= entry_mem[rd_idx];
   end

   // Valid bits, cleared at reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (tbl_cmd.wr_en) begin
         valid_ff[tbl_cmd.idx[ENT_AW-1:0]] <= 1'b1;
      end else if (tbl_cmd.clr_en) begin
         valid_ff[tbl_cmd.idx[ENT_AW-1:0]] <= 1'b0;
      end
   end

   assign rd_entry = rd_entry_ff;
   assign rd_valid = valid_ff[rd_idx];

endmodule
